@@ rtl/core/bayer_bilinear_demosaic_macros.svh @@
// ----------------------------------------------------------------------------
// Bayer bilinear demosaic assertion macros
// Concurrent checks on clk with reset arst_n; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BAYER_BILINEAR_DEMOSAIC_MACROS_SVH
`define BAYER_BILINEAR_DEMOSAIC_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define BBD_ASSERT_IMP(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("bbd assertion failed");

// Next-cycle implication.
`define BBD_ASSERT_NXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("bbd assertion failed");

`else

`define BBD_ASSERT_IMP(label, a, b)
`define BBD_ASSERT_NXT(label, a, b)

`endif

`endif

@@ rtl/core/bbd_pkg.sv @@
// ----------------------------------------------------------------------------
// Bayer bilinear demosaic package
// Sizes, register indexes and the stage-1 transaction record shared by the
// window front end and the color interpolation stage.
// ----------------------------------------------------------------------------
package bbd_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int HEIGHT_CAP = 2048;
	localparam int WIDTH_CAP = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
	localparam int STORE_DEPTH = WIDTH_CAP;
	localparam int ADDR_W = $clog2(STORE_DEPTH);

	localparam int PIX_W = 8;
	localparam int COORD_W = 11;
	localparam int CFG_W = 12;
	localparam int SIZE_MIN = 3;

	localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

	typedef enum logic {
		REG_FRAME_WIDTH = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_index_t;

	// Item held in stage 1: the full 3x3 neighborhood, win[row][col], with
	// row 0 two lines back and column 2 the newest column.
	typedef struct packed {
		logic valid;
		logic prod;
		logic last;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [2:0][2:0][PIX_W-1:0] win;
	} stage1_t;

endpackage

@@ rtl/core/bbd_front.sv @@
// ----------------------------------------------------------------------------
// Bayer bilinear demosaic front end
// Frame size registers, raster position counters, the two line stores and the
// 3x3 window feeding the stage-1 register.
// ----------------------------------------------------------------------------
module bbd_front (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [bbd_pkg::CFG_W-1:0] cfg_data,
	input  logic pix_valid,
	output logic pix_ready,
	input  logic [bbd_pkg::PIX_W-1:0] raw_pixel,
	input  logic frame_start,
	input  logic take,
	output bbd_pkg::stage1_t s1
);

	logic [bbd_pkg::CFG_W-1:0] width_q, height_q, eff_w, eff_h;
	logic [bbd_pkg::COORD_W-1:0] col_q, row_q;
	logic [bbd_pkg::CFG_W-1:0] c0, r0, c1, r1, r2, cn, rn;
	logic accept, byp;
	logic [bbd_pkg::ADDR_W-1:0] addr;

	logic [bbd_pkg::PIX_W-1:0] store_upper [bbd_pkg::STORE_DEPTH];
	logic [bbd_pkg::PIX_W-1:0] store_lower [bbd_pkg::STORE_DEPTH];

	logic valid_s1, prod_s1, last_s1, byp_s1;
	logic [bbd_pkg::COORD_W-1:0] row_s1, col_s1;
	logic [bbd_pkg::ADDR_W-1:0] addr_s1;
	logic [bbd_pkg::PIX_W-1:0] pix_s1, up_rd_s1, lo_rd_s1, byp_up_s1, byp_lo_s1;
	logic [bbd_pkg::PIX_W-1:0] up_eff, lo_eff;
	logic [5:0][bbd_pkg::PIX_W-1:0] wc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= bbd_pkg::WIDTH_RESET;
			height_q <= bbd_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (bbd_pkg::reg_index_t'(cfg_index))
				bbd_pkg::REG_FRAME_WIDTH: width_q <= cfg_data;
				bbd_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < bbd_pkg::CFG_W'(bbd_pkg::SIZE_MIN))
			eff_w = bbd_pkg::CFG_W'(bbd_pkg::SIZE_MIN);
		else if (width_q > bbd_pkg::CFG_W'(bbd_pkg::WIDTH_CAP))
			eff_w = bbd_pkg::CFG_W'(bbd_pkg::WIDTH_CAP);
		else
			eff_w = width_q;
		if (height_q < bbd_pkg::CFG_W'(bbd_pkg::SIZE_MIN))
			eff_h = bbd_pkg::CFG_W'(bbd_pkg::SIZE_MIN);
		else if (height_q > bbd_pkg::CFG_W'(bbd_pkg::HEIGHT_CAP))
			eff_h = bbd_pkg::CFG_W'(bbd_pkg::HEIGHT_CAP);
		else
			eff_h = height_q;
	end

	// Position of the incoming sample. The counters are normally already in
	// range; the extra wrap covers a size that shrank since the last sample.
	always_comb begin
		c0 = frame_start ? '0 : {1'b0, col_q};
		r0 = frame_start ? '0 : {1'b0, row_q};
		if (c0 >= eff_w) begin
			c1 = '0;
			r1 = r0 + 1'b1;
		end else begin
			c1 = c0;
			r1 = r0;
		end
		r2 = (r1 >= eff_h) ? '0 : r1;
		cn = c1 + 1'b1;
		rn = r2;
		if (cn >= eff_w) begin
			cn = '0;
			rn = r2 + 1'b1;
			if (rn >= eff_h)
				rn = '0;
		end
	end

	assign pix_ready = !valid_s1 || take;
	assign accept = pix_valid && pix_ready;
	assign addr = c1[bbd_pkg::ADDR_W-1:0];

	// The item leaving stage 1 writes its column at the same edge; a new item on
	// the same column must see those values instead of the stale read.
	assign byp = valid_s1 && take && (addr == addr_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				col_q <= cn[bbd_pkg::COORD_W-1:0];
				row_q <= rn[bbd_pkg::COORD_W-1:0];
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= (r2 >= bbd_pkg::CFG_W'(2)) && (c1 >= bbd_pkg::CFG_W'(2));
			last_s1 <= (r2 == eff_h - 1'b1) && (c1 == eff_w - 1'b1);
			row_s1 <= r2[bbd_pkg::COORD_W-1:0] - 1'b1;
			col_s1 <= c1[bbd_pkg::COORD_W-1:0] - 1'b1;
			addr_s1 <= addr;
			pix_s1 <= raw_pixel;
			byp_s1 <= byp;
			byp_up_s1 <= lo_eff;
			byp_lo_s1 <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_s1 <= store_upper[addr];
			lo_rd_s1 <= store_lower[addr];
		end
		if (valid_s1 && take) begin
			store_upper[addr_s1] <= lo_eff;
			store_lower[addr_s1] <= pix_s1;
		end
	end

	assign up_eff = byp_s1 ? byp_up_s1 : up_rd_s1;
	assign lo_eff = byp_s1 ? byp_lo_s1 : lo_rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q <= '0;
		end else if (valid_s1 && take) begin
			wc_q <= {pix_s1, lo_eff, up_eff, wc_q[5], wc_q[4], wc_q[3]};
		end
	end

	always_comb begin
		s1.valid = valid_s1;
		s1.prod = prod_s1;
		s1.last = last_s1;
		s1.row = row_s1;
		s1.col = col_s1;
		s1.win[0][0] = wc_q[0];
		s1.win[1][0] = wc_q[1];
		s1.win[2][0] = wc_q[2];
		s1.win[0][1] = wc_q[3];
		s1.win[1][1] = wc_q[4];
		s1.win[2][1] = wc_q[5];
		s1.win[0][2] = up_eff;
		s1.win[1][2] = lo_eff;
		s1.win[2][2] = pix_s1;
	end

endmodule

@@ rtl/core/bbd_interp.sv @@
// ----------------------------------------------------------------------------
// Bayer bilinear demosaic color interpolation
// Fills in the two missing colors of the window center from its same-color
// neighbors and holds the result in the output register.
// ----------------------------------------------------------------------------
module bbd_interp (
	input  logic clk,
	input  logic arst_n,
	input  bbd_pkg::stage1_t s1,
	output logic take,
	output logic rgb_valid,
	input  logic rgb_ready,
	output logic [bbd_pkg::PIX_W-1:0] red,
	output logic [bbd_pkg::PIX_W-1:0] green,
	output logic [bbd_pkg::PIX_W-1:0] blue,
	output logic [bbd_pkg::COORD_W-1:0] out_column,
	output logic [bbd_pkg::COORD_W-1:0] out_row,
	output logic last
);

	logic out_free, load;
	logic [bbd_pkg::PIX_W+1:0] diag, cross_sum;
	logic [bbd_pkg::PIX_W:0] vert, horiz;
	logic [bbd_pkg::PIX_W-1:0] diag_m, cross_m, vert_m, horiz_m, center;
	logic [bbd_pkg::PIX_W-1:0] red_d, green_d, blue_d;
	logic valid_q;
	logic [bbd_pkg::PIX_W-1:0] red_q, green_q, blue_q;
	logic [bbd_pkg::COORD_W-1:0] col_q, row_q;
	logic last_q;

	assign out_free = !valid_q || rgb_ready;
	assign take = s1.valid && (!s1.prod || out_free);
	assign load = take && s1.prod;

	always_comb begin
		diag = 10'(s1.win[0][0]) + 10'(s1.win[0][2]) + 10'(s1.win[2][0]) + 10'(s1.win[2][2]);
		cross_sum = 10'(s1.win[0][1]) + 10'(s1.win[2][1]) +
			10'(s1.win[1][0]) + 10'(s1.win[1][2]);
		vert = 9'(s1.win[0][1]) + 9'(s1.win[2][1]);
		horiz = 9'(s1.win[1][0]) + 9'(s1.win[1][2]);
		diag_m = diag[bbd_pkg::PIX_W+1:2];
		cross_m = cross_sum[bbd_pkg::PIX_W+1:2];
		vert_m = vert[bbd_pkg::PIX_W:1];
		horiz_m = horiz[bbd_pkg::PIX_W:1];
		center = s1.win[1][1];
		// Row and column parity of the center pick the site color.
		unique case ({s1.row[0], s1.col[0]})
			2'b00: begin
				red_d = diag_m;
				green_d = cross_m;
				blue_d = center;
			end
			2'b11: begin
				red_d = center;
				green_d = cross_m;
				blue_d = diag_m;
			end
			2'b01: begin
				red_d = vert_m;
				green_d = center;
				blue_d = horiz_m;
			end
			default: begin
				red_d = horiz_m;
				green_d = center;
				blue_d = vert_m;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			red_q <= red_d;
			green_q <= green_d;
			blue_q <= blue_d;
			col_q <= s1.col;
			row_q <= s1.row;
			last_q <= s1.last;
		end
	end

	assign rgb_valid = valid_q;
	assign red = red_q;
	assign green = green_q;
	assign blue = blue_q;
	assign out_column = col_q;
	assign out_row = row_q;
	assign last = last_q;

endmodule

@@ rtl/core/bayer_bilinear_demosaic.sv @@
// ----------------------------------------------------------------------------
// Bayer bilinear demosaic
// Streaming BGGR to RGB conversion with two line stores and a 3x3 window.
// ----------------------------------------------------------------------------
// Raw 8-bit samples enter in raster order, one transaction per clock while
// pix_ready is high, and every interior pixel leaves as an RGB transaction tagged
// with its row and column; a sample at row r, column c (both at least 2) yields the
// pixel at (r-1, c-1) via the stage-1 and output registers. Border pixels give no
// output. This rate is set by the line stores, which take one read and one write
// each per clock. Line store contents are undefined after reset and need no
// clearing: each frame fills them before they are used. The user must write the
// frame size only while the stream is idle; the block does not enforce it.
module bayer_bilinear_demosaic (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [bbd_pkg::CFG_W-1:0] cfg_data,
	input  logic pix_valid,
	output logic pix_ready,
	input  logic [bbd_pkg::PIX_W-1:0] raw_pixel,
	input  logic frame_start,
	output logic rgb_valid,
	input  logic rgb_ready,
	output logic [bbd_pkg::PIX_W-1:0] red,
	output logic [bbd_pkg::PIX_W-1:0] green,
	output logic [bbd_pkg::PIX_W-1:0] blue,
	output logic [bbd_pkg::COORD_W-1:0] out_column,
	output logic [bbd_pkg::COORD_W-1:0] out_row,
	output logic last
);

`include "bayer_bilinear_demosaic_macros.svh"

	bbd_pkg::stage1_t s1;
	logic take;

	bbd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.raw_pixel(raw_pixel),
		.frame_start(frame_start),
		.take(take),
		.s1(s1)
	);

	bbd_interp u_interp (
		.clk(clk),
		.arst_n(arst_n),
		.s1(s1),
		.take(take),
		.rgb_valid(rgb_valid),
		.rgb_ready(rgb_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.out_column(out_column),
		.out_row(out_row),
		.last(last)
	);

	// Every result is an interior pixel.
	`BBD_ASSERT_IMP(a_interior, rgb_valid, (out_column != '0) && (out_row != '0))
	// A stage-1 transaction that cannot move on is kept, not dropped.
	`BBD_ASSERT_NXT(a_s1_hold, s1.valid && !take, s1.valid)
	// With stage 1 empty the input side is always open.
	`BBD_ASSERT_IMP(a_ready_empty, !s1.valid, pix_ready)
	// A stalled output with a pending result behind it closes the input.
	`BBD_ASSERT_IMP(a_backpressure, rgb_valid && !rgb_ready && s1.valid && s1.prod, !pix_ready)

endmodule
